[rtl/core/pdrs_pkg.sv]
// Shared types, codes and reset values for the peer-delay request sequencer.
package pdrs_pkg;

  localparam int unsigned TimeW  = 63;
  localparam int unsigned LimitW = 36;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 64;

  localparam logic [LimitW-1:0] RequestIntervalRst = 36'd1000000000;
  localparam logic [LimitW-1:0] ResponseTimeoutRst = 36'd100000000;

  // Register index, taken from the 8-byte word address
  localparam logic RegRequestInterval = 1'b0;
  localparam logic RegResponseTimeout = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_TICK     = 3'd0,
    KIND_ENABLED  = 3'd1,
    KIND_DISABLED = 3'd2,
    KIND_INTERVAL = 3'd3,
    KIND_RESP     = 3'd4,
    KIND_RESP_FUP = 3'd5,
    KIND_TIMEOUT  = 3'd6
  } kind_e;

  typedef enum logic [4:0] {
    PH_OFF   = 5'b00001,
    PH_INIT  = 5'b00010,
    PH_SEND  = 5'b00100,
    PH_WRESP = 5'b01000,
    PH_WFUP  = 5'b10000
  } phase_e;

  localparam logic [PhaseW-1:0] PhaseCodeOff   = 3'd0;
  localparam logic [PhaseW-1:0] PhaseCodeInit  = 3'd1;
  localparam logic [PhaseW-1:0] PhaseCodeSend  = 3'd2;
  localparam logic [PhaseW-1:0] PhaseCodeWresp = 3'd3;
  localparam logic [PhaseW-1:0] PhaseCodeWfup  = 3'd4;

  typedef struct packed {
    logic [LimitW-1:0] request_interval_ns;
    logic [LimitW-1:0] response_timeout_ns;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] machine_phase;
    logic              request_sent;
    logic [SeqW-1:0]   request_sequence;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e p);
    logic [PhaseW-1:0] code;
    unique case (p)
      PH_OFF:   code = PhaseCodeOff;
      PH_INIT:  code = PhaseCodeInit;
      PH_SEND:  code = PhaseCodeSend;
      PH_WRESP: code = PhaseCodeWresp;
      PH_WFUP:  code = PhaseCodeWfup;
      default:  code = PhaseCodeOff;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/pdrs_cfg.sv]
// APB register file holding the request interval and response timeout.
module pdrs_cfg
  import pdrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // 8-byte registers: bit 3 picks the register, low bits are the byte offset
  assign reg_sel = paddr[3];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegRequestInterval: cfg_d.request_interval_ns = pwdata[LimitW-1:0];
        RegResponseTimeout: cfg_d.response_timeout_ns = pwdata[LimitW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegRequestInterval: prdata = {{(ApbDataW-LimitW){1'b0}}, cfg_q.request_interval_ns};
      RegResponseTimeout: prdata = {{(ApbDataW-LimitW){1'b0}}, cfg_q.response_timeout_ns};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_interval_ns <= RequestIntervalRst;
      cfg_q.response_timeout_ns <= ResponseTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/pdrs_core.sv]
// Phase machine, request timing and sequence numbering for one beat.
module pdrs_core
  import pdrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [TimeW-1:0] now_ns_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] latest_q, latest_d;
  logic [TimeW-1:0] last_req_q, last_req_d;
  logic [SeqW-1:0]  seq_q, seq_d;

  kind_e            kind;
  logic [TimeW-1:0] tick_time;
  logic [TimeW:0]   diff;
  logic             ahead;
  logic             interval_met;
  logic             timeout_hit;
  logic             issue;

  assign kind      = kind_e'(kind_i);
  assign tick_time = (kind == KIND_TICK) ? now_ns_i : latest_q;

  // Borrow out of the subtract flags time running backwards
  assign diff         = {1'b0, now_ns_i} - {1'b0, last_req_q};
  assign ahead        = ~diff[TimeW];
  assign interval_met = ahead &&
      (diff[TimeW-1:0] >= {{(TimeW-LimitW){1'b0}}, cfg_i.request_interval_ns});
  assign timeout_hit  = ahead &&
      (diff[TimeW-1:0] > {{(TimeW-LimitW){1'b0}}, cfg_i.response_timeout_ns});

  always_comb begin
    phase_d = phase_q;
    issue   = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        unique case (phase_q) inside
          PH_INIT: issue = 1'b1;
          PH_SEND: issue = interval_met;
          PH_WRESP, PH_WFUP: begin
            if (timeout_hit) phase_d = PH_SEND;
          end
          default: phase_d = phase_q;
        endcase
      end
      KIND_ENABLED: begin
        if (phase_q == PH_OFF) phase_d = PH_INIT;
      end
      KIND_DISABLED: phase_d = PH_OFF;
      KIND_INTERVAL: issue = (phase_q == PH_SEND);
      KIND_RESP: begin
        if (phase_q == PH_WRESP) phase_d = PH_WFUP;
      end
      KIND_RESP_FUP: begin
        if (phase_q == PH_WFUP) phase_d = PH_SEND;
      end
      KIND_TIMEOUT: begin
        if (phase_q == PH_WRESP || phase_q == PH_WFUP) phase_d = PH_SEND;
      end
      default: phase_d = phase_q;
    endcase
    if (issue) phase_d = PH_WRESP;
  end

  assign latest_d   = tick_time;
  assign last_req_d = issue ? tick_time : last_req_q;
  assign seq_d      = issue ? seq_q + 1'b1 : seq_q;

  assign res_o.machine_phase    = phase_code(phase_d);
  assign res_o.request_sent     = issue;
  assign res_o.request_sequence = issue ? seq_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OFF;
      latest_q   <= '0;
      last_req_q <= '0;
      seq_q      <= '0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      latest_q   <= latest_d;
      last_req_q <= last_req_d;
      seq_q      <= seq_d;
    end
  end

endmodule

[rtl/core/peer_delay_request_sequencer_top.sv]
// Top level of the peer-delay request sequencer: input stage, core, result stage.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   kind_i, now_ns_i
//   out      source     out_valid_o / out_stall_i machine_phase_o, request_sent_o,
//                                                 request_sequence_o
//   cfg      APB slave  psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each beat is held in the input register and is then resolved by the core
// into the result register, one beat per cycle sustained while out_stall_i is
// low. Compares of elapsed time against the interval and timeout limits set the
// path. Reset clears the phase, the timestamps and the sequence number; no
// clearing pass is needed. A stall on the output holds the result register and,
// once the input register is also full, raises in_stall_o in the same cycle.
module peer_delay_request_sequencer_top
  import pdrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [TimeW-1:0]    now_ns_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PhaseW-1:0]   machine_phase_o,
  output logic                request_sent_o,
  output logic [SeqW-1:0]     request_sequence_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  // input stage
  logic             s1_valid_q, s1_valid_d;
  logic [KindW-1:0] s1_kind_q;
  logic [TimeW-1:0] s1_now_q;

  // result stage
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t res;

  logic in_acc;
  logic adv;

  pdrs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the input beat into the result register whenever that register is
  // empty or being drained this cycle.
  assign adv        = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign s1_valid_d  = in_acc | (s1_valid_q & ~adv);
  assign out_valid_d = adv | (out_valid_q & out_stall_i);

  pdrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .kind_i   (s1_kind_q),
    .now_ns_i (s1_now_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on accept / advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= kind_i;
      s1_now_q  <= now_ns_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign machine_phase_o    = out_q.machine_phase;
  assign request_sent_o     = out_q.request_sent;
  assign request_sequence_o = out_q.request_sequence;

endmodule

[rtl/core/pdrs_checker.sv]
// Port-level checks for the peer-delay request sequencer, bound to the top level.
module pdrs_checker
  import pdrs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PhaseW-1:0] machine_phase_o,
  input logic              request_sent_o,
  input logic [SeqW-1:0]   request_sequence_o
);

  // A beat that sends a request always leaves the machine waiting for a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && request_sent_o) |-> (machine_phase_o == PhaseCodeWresp))
    else $error("request sent without entering wait-response");

  // No request, no sequence number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !request_sent_o) |-> (request_sequence_o == '0))
    else $error("sequence number reported without a request");

  // Reported phase is one of the five legal codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (machine_phase_o <= PhaseCodeWfup))
    else $error("illegal phase code on result");

  // A stalled result stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(machine_phase_o) &&
      $stable(request_sent_o) && $stable(request_sequence_o)))
    else $error("stalled result changed");

endmodule

bind peer_delay_request_sequencer_top pdrs_checker u_pdrs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .machine_phase_o    (machine_phase_o),
  .request_sent_o     (request_sent_o),
  .request_sequence_o (request_sequence_o)
);
